@@ hw/rtl/ppu_pkg.sv @@
// Particle pool update: shared types, constants and helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppu_pkg;
  localparam int MaxParticles = 256;
  localparam int IdxW = $clog2(MaxParticles);
  localparam int CntW = IdxW + 1;
  // particle word: pos_x, pos_y, vel_x, vel_y, life, shade, alpha
  localparam int PartW = 24 * 5 + 9 + 16;

  typedef struct packed {
    logic        mode;
    logic [15:0] delta_time;
    logic signed [23:0] ball_pos_x;
    logic signed [23:0] ball_pos_y;
    logic signed [23:0] ball_vel_x;
    logic signed [23:0] ball_vel_y;
    logic [6:0]  offset_rand_first;
    logic [6:0]  shade_rand_first;
    logic [6:0]  offset_rand_second;
    logic [6:0]  shade_rand_second;
    logic [7:0]  read_index;
  } ppu_in_t;

  typedef struct packed {
    logic signed [23:0] part_pos_x;
    logic signed [23:0] part_pos_y;
    logic [8:0]  part_shade;
    logic signed [15:0] part_alpha;
    logic signed [23:0] part_life;
    logic        part_alive;
    logic [7:0]  respawned_first;
    logic [7:0]  respawned_second;
  } ppu_out_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] life;
    logic [8:0]  shade;
    logic signed [15:0] alpha;
  } part_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_READ, ST_READ_OUT, ST_SRCH_ADDR, ST_SRCH_CHK,
    ST_SPAWN, ST_UPD_ADDR, ST_UPD_MUL, ST_UPD_WR, ST_DONE
  } ppu_state_t;

  localparam part_t PartReset = '{pos_x: '0, pos_y: '0, vel_x: '0, vel_y: '0,
                                  life: '0, shade: 9'd256, alpha: 16'sd16384};

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'sh7fffff;
    if (v < -26'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // offset (r-50)*256/10 rounded away from zero; divide by 10 through
  // a reciprocal multiply, exact for magnitudes up to 2^17
  function automatic logic signed [15:0] offset_of(input logic [6:0] r);
    logic signed [7:0] d;
    logic [7:0] dm;
    logic [15:0] x;
    logic [31:0] p;
    logic [15:0] q;
    d = $signed({1'b0, r}) - 8'sd50;
    dm = d[7] ? 8'(-d) : 8'(d);
    x = {dm, 8'd0} + 16'd5;
    p = 32'(x) * 32'd52429;
    q = 16'(p >> 19);
    return d[7] ? -q : q;
  endfunction

  // divide by 100 through a reciprocal multiply, exact below 43690
  function automatic logic [8:0] shade_of(input logic [6:0] r);
    logic [15:0] x;
    logic [31:0] p;
    x = {r, 8'd0} + 16'd50;
    p = 32'(x) * 32'd5243;
    return 9'(16'd128 + 16'(p >> 19));
  endfunction

  // v/10 rounded, ties away from zero; reciprocal exact below 2^26
  function automatic logic signed [23:0] div10_round(input logic signed [23:0] v);
    logic [23:0] m;
    logic [24:0] x;
    logic [51:0] p;
    logic [23:0] q;
    m = v[23] ? 24'(-v) : 24'(v);
    x = 25'(m) + 25'd5;
    p = 52'(x) * 52'd13421773;
    q = 24'(p >> 27);
    return v[23] ? -q : q;
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/particle_pool_update.sv @@
// Particle pool update top level: sequencer around one particle RAM.
// Depends on ppu_pkg and ppu_ram.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block sweeps every RAM entry once to clear it, holding busy
// high. A read item passes through a read and a read-out state. A tick item
// takes two circular searches, each probe an address and a check state, then
// an update pass over every pool entry through address, multiply and write.
// Each result appears for one cycle with out_valid; it cannot be held off.
module particle_pool_update import ppu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire ppu_in_t  in_data,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [8:0] cfg_data,
  output logic          out_valid,
  output ppu_out_t      out_data
);
  ppu_state_t state_r, state_nxt;
  ppu_in_t    item_r, item_nxt;
  logic [8:0] pool_r;
  logic [CntW-1:0] cnt_r, cnt_nxt, probes_r, probes_nxt;
  logic [IdxW-1:0] sstart_r, sstart_nxt;
  logic       rsp_r, rsp_nxt;
  logic [7:0] k0_r, k0_nxt, k1_r, k1_nxt;
  part_t      cur_r, cur_nxt;
  logic signed [40:0] mx_r, my_r, mx_nxt, my_nxt;
  ppu_out_t   out_r, out_nxt;
  logic       outv_r, outv_nxt;
  logic [CntW-1:0] n;
  logic       we;
  logic [IdxW-1:0] waddr, raddr;
  part_t      wdata, rdata;
  logic [PartW-1:0] rraw;

  ppu_ram #(.Width(PartW), .Depth(MaxParticles)) u_ram (
    .clk, .we, .waddr, .wdata(PartW'(wdata)), .raddr, .rdata(rraw)
  );
  assign rdata = part_t'(rraw);

  always_comb begin
    n = (pool_r == 9'd0) ? CntW'(1) :
        (pool_r > 9'(MaxParticles)) ? CntW'(MaxParticles) : CntW'(pool_r);
  end

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = outv_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pool_r <= 9'd256;
    else if (cfg_valid && cfg_ready) pool_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; cnt_r <= '0; sstart_r <= '0; outv_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; sstart_r <= sstart_nxt;
      outv_r <= outv_nxt;
    end
    item_r <= item_nxt; probes_r <= probes_nxt; rsp_r <= rsp_nxt;
    k0_r <= k0_nxt; k1_r <= k1_nxt; cur_r <= cur_nxt;
    mx_r <= mx_nxt; my_r <= my_nxt; out_r <= out_nxt;
  end

  logic [IdxW-1:0] ci;
  logic [IdxW-1:0] kk;
  logic signed [15:0] off;
  logic signed [25:0] lt, px, py;
  logic signed [40:0] rx, ry;
  logic signed [16:0] al;
  logic [6:0] offr, shr;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; sstart_nxt = sstart_r;
    item_nxt = item_r; probes_nxt = probes_r; rsp_nxt = rsp_r;
    k0_nxt = k0_r; k1_nxt = k1_r; cur_nxt = cur_r; mx_nxt = mx_r; my_nxt = my_r;
    out_nxt = out_r; outv_nxt = 1'b0;
    we = 1'b0; waddr = cnt_r[IdxW-1:0]; wdata = PartReset; raddr = cnt_r[IdxW-1:0];
    ci = cnt_r[IdxW-1:0];
    kk = '0; off = '0; lt = '0; px = '0; py = '0; rx = '0; ry = '0; al = '0;
    offr = rsp_r ? item_r.offset_rand_second : item_r.offset_rand_first;
    shr = rsp_r ? item_r.shade_rand_second : item_r.shade_rand_first;
    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        cnt_nxt = cnt_r + CntW'(1);
        if (cnt_r == CntW'(MaxParticles - 1)) begin
          cnt_nxt = '0; state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          rsp_nxt = 1'b0;
          if (in_data.mode) begin
            raddr = in_data.read_index;
            state_nxt = ST_READ;
          end else begin
            // search begins at the stored search start, or at 0 if that lies outside the pool
            cnt_nxt = (CntW'(sstart_r) < n) ? CntW'(sstart_r) : '0;
            probes_nxt = '0;
            state_nxt = ST_SRCH_ADDR;
          end
        end
      end
      ST_READ: begin
        // hold the read address so the data stays for the next cycle
        raddr = item_r.read_index;
        state_nxt = ST_READ_OUT;
      end
      ST_READ_OUT: begin
        out_nxt = '0;
        if (CntW'(item_r.read_index) < n) begin
          out_nxt.part_pos_x = rdata.pos_x;
          out_nxt.part_pos_y = rdata.pos_y;
          out_nxt.part_shade = rdata.shade;
          out_nxt.part_alpha = rdata.alpha;
          out_nxt.part_life = rdata.life;
          out_nxt.part_alive = (rdata.life > 24'sd0);
        end
        outv_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SRCH_ADDR: state_nxt = ST_SRCH_CHK;  // raddr = cnt_r
      ST_SRCH_CHK: begin
        if (rdata.life <= 24'sd0) begin
          state_nxt = ST_SPAWN;
        end else if (probes_r + CntW'(1) == n) begin
          cnt_nxt = '0; state_nxt = ST_SPAWN;
        end else begin
          probes_nxt = probes_r + CntW'(1);
          cnt_nxt = (cnt_r + CntW'(1) == n) ? '0 : cnt_r + CntW'(1);
          state_nxt = ST_SRCH_ADDR;
        end
      end
      ST_SPAWN: begin
        kk = ci;
        off = offset_of(offr);
        wdata.pos_x = sat24(26'(item_r.ball_pos_x) + 26'(off));
        wdata.pos_y = sat24(26'(item_r.ball_pos_y) + 26'(off));
        wdata.vel_x = div10_round(item_r.ball_vel_x);
        wdata.vel_y = div10_round(item_r.ball_vel_y);
        wdata.shade = shade_of(shr);
        wdata.alpha = 16'sd16384;
        wdata.life = 24'sd65536;
        we = 1'b1; waddr = kk;
        sstart_nxt = kk;
        if (!rsp_r) k0_nxt = 8'(kk); else k1_nxt = 8'(kk);
        probes_nxt = '0;
        if (!rsp_r) begin
          rsp_nxt = 1'b1;  // second search starts at the new start
          state_nxt = ST_SRCH_ADDR;
        end else begin
          cnt_nxt = '0;
          state_nxt = ST_UPD_ADDR;
        end
      end
      ST_UPD_ADDR: state_nxt = ST_UPD_MUL;
      ST_UPD_MUL: begin
        cur_nxt = rdata;
        mx_nxt = 41'(rdata.vel_x) * $signed({25'd0, item_r.delta_time});
        my_nxt = 41'(rdata.vel_y) * $signed({25'd0, item_r.delta_time});
        state_nxt = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        wdata = cur_r;
        lt = 26'(cur_r.life) - 26'($signed({1'b0, item_r.delta_time}));
        wdata.life = sat24(lt);
        if (sat24(lt) > 24'sd0) begin
          rx = mx_r[40] ? -((-mx_r + 41'sd32768) >>> 16) : ((mx_r + 41'sd32768) >>> 16);
          ry = my_r[40] ? -((-my_r + 41'sd32768) >>> 16) : ((my_r + 41'sd32768) >>> 16);
          px = 26'(cur_r.pos_x) + 26'(rx);
          py = 26'(cur_r.pos_y) + 26'(ry);
          wdata.pos_x = sat24(px);
          wdata.pos_y = sat24(py);
          al = 17'(cur_r.alpha) - 17'($signed({1'b0, 16'((17'(item_r.delta_time) + 17'd1) >> 1)}));
          wdata.alpha = (al < -17'sd32768) ? 16'sh8000 : al[15:0];
        end
        we = 1'b1;
        if (cnt_r + CntW'(1) == n) state_nxt = ST_DONE;
        else begin
          cnt_nxt = cnt_r + CntW'(1); state_nxt = ST_UPD_ADDR;
        end
      end
      ST_DONE: begin
        out_nxt = '0;
        out_nxt.respawned_first = k0_r;
        out_nxt.respawned_second = k1_r;
        outv_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // a result only leaves from the finishing states
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_DONE || $past(state_r) == ST_READ_OUT))
    else $error("result without finishing state");
  // clearing sweep holds the block busy
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> busy) else $error("busy low during clear");
  // update pass never addresses beyond the pool
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD_WR |-> cnt_r < n) else $error("update beyond pool");
endmodule
`default_nettype wire

@@ hw/rtl/ppu_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ppu_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
